// File: sv/k_combination_mask_generator_assert.svh
// Assertion macros shared by the combination mask generator top level.
`ifndef K_COMBINATION_MASK_GENERATOR_ASSERT_SVH
`define K_COMBINATION_MASK_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define KCMG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define KCMG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/kcmg_pkg.sv
// Shared types, codes and widths of the combination mask generator.
`default_nettype none
package kcmg_pkg;

    localparam int MASK_W    = 64;
    localparam int IDX_W     = $clog2(MASK_W);
    localparam int CFG_W     = 7;
    localparam int ROM_SIDE  = MASK_W + 1;
    localparam int ROM_DEPTH = ROM_SIDE * ROM_SIDE;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);

    localparam logic [CFG_W-1:0] MAX_BITS = CFG_W'(MASK_W);
    localparam logic [CFG_W-1:0] LAST_ROW = CFG_W'(ROM_SIDE - 1);

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_LOAD = 2'd0;
    localparam t_cmd CMD_STEP = 2'd1;
    localparam t_cmd CMD_SEEK = 2'd2;
    localparam t_cmd CMD_NONE = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_EXH    = 2'd1;
    localparam t_status ST_RANGE  = 2'd2;
    localparam t_status ST_BADCFG = 2'd3;

    typedef logic t_cfg_idx;
    localparam t_cfg_idx CFG_IDX_LEN  = 1'b0;
    localparam t_cfg_idx CFG_IDX_ONES = 1'b1;

    // mask register update select
    typedef logic [2:0] t_mop;
    localparam t_mop MOP_HOLD  = 3'd0;
    localparam t_mop MOP_LOAD  = 3'd1;
    localparam t_mop MOP_STEP  = 3'd2;
    localparam t_mop MOP_ZERO  = 3'd3;
    localparam t_mop MOP_BUILT = 3'd4;

    typedef struct packed {
        logic    fill;
        logic    take;
        logic    rd_range;
        t_mop    mop;
        logic    set_st;
        t_status st;
        logic    walk_init;
        logic    walk_take;
        logic    walk_place;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic fill_done;
        logic cfg_bad;
        logic k_zero;
        t_cmd cmd;
        logic range_bad;
        logic walk_cont;
        logic walk_take;
        logic place_oob;
        logic place_last;
        logic step_ok;
    } t_dp_stat;

endpackage
`default_nettype wire

// File: sv/kcmg_dp.sv
// Datapath: config, mask register, step logic, binomial memory and unrank walk.
`default_nettype none
module kcmg_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire kcmg_pkg::t_cfg_idx            i_cfg_index,
    input  wire logic [kcmg_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire kcmg_pkg::t_cmd                i_command,
    input  wire logic [kcmg_pkg::MASK_W-1:0]   i_rank,
    input  wire kcmg_pkg::t_dp_cmd             i_ctl,
    output kcmg_pkg::t_dp_stat                 o_stat,
    output logic [kcmg_pkg::MASK_W-1:0]        o_mask,
    output kcmg_pkg::t_status                  o_status
);
    import kcmg_pkg::*;

    function automatic logic [MASK_W-1:0] low_ones(input logic [CFG_W-1:0] cnt);
        logic [MASK_W-1:0] m;
        for (int b = 0; b < MASK_W; b++) begin
            m[b] = (CFG_W'(b) < cnt);
        end
        return m;
    endfunction

    function automatic logic [IDX_W-1:0] lowest_index(input logic [MASK_W-1:0] x);
        logic [IDX_W-1:0] idx;
        idx = IDX_W'(MASK_W - 1);
        for (int b = MASK_W - 1; b >= 0; b--) begin
            if (x[b]) begin
                idx = IDX_W'(b);
            end
        end
        return idx;
    endfunction

    function automatic logic [ROM_AW-1:0] rom_addr(input logic [CFG_W-1:0] n,
                                                   input logic [CFG_W-1:0] k);
        return (ROM_AW'(n) << IDX_W) + ROM_AW'(n) + ROM_AW'(k);
    endfunction

    logic [CFG_W-1:0]  r_mask_length;
    logic [CFG_W-1:0]  r_ones_count;
    logic [MASK_W-1:0] r_mask;
    logic [MASK_W-1:0] n_mask;
    t_cmd              r_cmd;
    logic [MASK_W-1:0] r_rank;
    t_status           r_st;
    logic [MASK_W-1:0] r_out_mask;
    t_status           r_out_status;

    // Pascal fill pipeline
    logic [CFG_W-1:0]  r_fn;
    logic [CFG_W-1:0]  r_fk;
    logic              r_issue_done;
    logic              r_wv;
    logic [CFG_W-1:0]  r_wn;
    logic [CFG_W-1:0]  r_wk;
    logic              r_fill_done;
    logic [MASK_W-1:0] r_prev;
    logic [MASK_W-1:0] r_rdata;
    logic [MASK_W-1:0] r_rom [ROM_DEPTH];
    logic              issuing;
    logic              row_end;
    logic [CFG_W-1:0]  fill_n;
    logic [ROM_AW-1:0] rd_addr;
    logic [MASK_W-1:0] w_val;

    // step intermediates
    logic [MASK_W-1:0] step_low;
    logic [MASK_W:0]   step_wide;
    logic [MASK_W-1:0] r_sum;
    logic [MASK_W-1:0] r_diff;
    logic [IDX_W-1:0]  r_t0;
    logic              r_carry;
    logic [MASK_W-1:0] step_next;

    // unrank walk
    logic [CFG_W-1:0]  r_i;
    logic [CFG_W-1:0]  r_j;
    logic [MASK_W-1:0] r_built;
    logic [MASK_W-1:0] n_built;
    logic [CFG_W-1:0]  walk_n;
    logic [CFG_W-1:0]  walk_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_length <= CFG_W'(1);
            r_ones_count  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IDX_LEN:  r_mask_length <= i_cfg_data;
                CFG_IDX_ONES: r_ones_count  <= i_cfg_data;
            endcase
        end
    end

    // fill: issue a read of row n-1, write row n in the next cycle
    assign issuing = i_ctl.fill && !r_issue_done;
    assign row_end = (r_fk == r_fn);
    assign fill_n  = (r_fn == '0) ? '0 : r_fn - CFG_W'(1);
    assign w_val   = (r_wk == '0 || r_wk == r_wn) ? MASK_W'(1) : r_prev + r_rdata;
    assign walk_n  = r_mask_length - r_j - CFG_W'(1);
    assign walk_t  = r_i - CFG_W'(1);

    always_comb begin
        if (i_ctl.fill) begin
            rd_addr = rom_addr(fill_n, r_fk);
        end else if (i_ctl.rd_range) begin
            rd_addr = rom_addr(r_mask_length, r_ones_count);
        end else begin
            rd_addr = rom_addr(walk_n, walk_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fn         <= '0;
            r_fk         <= '0;
            r_issue_done <= 1'b0;
            r_wv         <= 1'b0;
            r_fill_done  <= 1'b0;
        end else begin
            r_wv <= issuing;
            if (issuing) begin
                r_fk <= row_end ? '0 : r_fk + CFG_W'(1);
                r_fn <= row_end ? r_fn + CFG_W'(1) : r_fn;
                if (row_end && r_fn == LAST_ROW) begin
                    r_issue_done <= 1'b1;
                end
            end
            if (r_wv && r_wn == LAST_ROW && r_wk == LAST_ROW) begin
                r_fill_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wn   <= r_fn;
        r_wk   <= r_fk;
        r_prev <= r_rdata;
    end

    always_ff @(posedge i_clk) begin
        if (r_wv) begin
            r_rom[rom_addr(r_wn, r_wk)] <= w_val;
        end
        r_rdata <= r_rom[rd_addr];
    end

    // step, first half: lowest set bit, sum and changed bits
    assign step_low  = r_mask & (~r_mask + MASK_W'(1));
    assign step_wide = {1'b0, r_mask} + {1'b0, step_low};

    always_ff @(posedge i_clk) begin
        r_sum   <= step_wide[MASK_W-1:0];
        r_carry <= step_wide[MASK_W];
        r_diff  <= step_wide[MASK_W-1:0] ^ r_mask;
        r_t0    <= lowest_index(r_mask);
    end

    // step, second half: spread the changed bits down past the lowest one
    assign step_next = r_sum | ((r_diff >> r_t0) >> 2);
    assign n_built   = r_built | (MASK_W'(1) << r_j[IDX_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_ctl.walk_init) begin
            r_i     <= r_ones_count;
            r_j     <= '0;
            r_built <= '0;
        end else if (i_ctl.walk_place) begin
            r_i     <= r_i - CFG_W'(1);
            r_j     <= r_j + CFG_W'(1);
            r_built <= n_built;
        end else if (i_ctl.walk_take) begin
            r_j <= r_j + CFG_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_cmd  <= i_command;
            r_rank <= i_rank;
        end else if (i_ctl.walk_take) begin
            r_rank <= r_rank - r_rdata;
        end
        if (i_ctl.set_st) begin
            r_st <= i_ctl.st;
        end
        if (i_ctl.out_load) begin
            r_out_mask   <= r_mask;
            r_out_status <= r_st;
        end
    end

    always_comb begin
        unique case (i_ctl.mop)
            MOP_LOAD:  n_mask = low_ones(r_ones_count);
            MOP_STEP:  n_mask = step_next;
            MOP_ZERO:  n_mask = '0;
            MOP_BUILT: n_mask = n_built;
            default:   n_mask = r_mask;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_comb begin
        o_stat.fill_done  = r_fill_done;
        o_stat.cfg_bad    = (r_mask_length == '0) || (r_mask_length > MAX_BITS) ||
                            (r_ones_count > r_mask_length);
        o_stat.k_zero     = (r_ones_count == '0);
        o_stat.cmd        = r_cmd;
        o_stat.range_bad  = (r_rank >= r_rdata);
        o_stat.walk_cont  = ({1'b0, r_j} + {1'b0, r_i}) <= {1'b0, r_mask_length};
        o_stat.walk_take  = (r_rdata <= r_rank);
        o_stat.place_oob  = (r_j >= r_mask_length);
        o_stat.place_last = (r_i == CFG_W'(1));
        o_stat.step_ok    = !((r_ones_count == '0) || (r_mask == '0) || r_carry ||
                              ((step_next & ~low_ones(r_mask_length)) != '0));
    end

    assign o_mask   = r_out_mask;
    assign o_status = r_out_status;

endmodule
`default_nettype wire

// File: sv/kcmg_ctrl.sv
// Controller: sequences fill, dispatch, step, seek walk and result hand-off.
`default_nettype none
module kcmg_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    input  wire kcmg_pkg::t_dp_stat  i_stat,
    output kcmg_pkg::t_dp_cmd        o_ctl
);
    import kcmg_pkg::*;

    localparam logic [2:0] S_FILL  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DISP  = 3'd2;
    localparam logic [2:0] S_STEP  = 3'd3;
    localparam logic [2:0] S_RANGE = 3'd4;
    localparam logic [2:0] S_WRD   = 3'd5;
    localparam logic [2:0] S_WCMP  = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       do_place;

    always_comb begin
        n_state  = r_state;
        o_ctl    = '0;
        do_place = 1'b0;
        unique case (r_state)
            S_FILL: begin
                o_ctl.fill = 1'b1;
                if (i_stat.fill_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.take = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                priority if (i_stat.cmd == CMD_NONE) begin
                    o_ctl.set_st = 1'b1;
                    o_ctl.st     = ST_OK;
                    n_state      = S_FIN;
                end else if (i_stat.cfg_bad) begin
                    o_ctl.set_st = 1'b1;
                    o_ctl.st     = ST_BADCFG;
                    n_state      = S_FIN;
                end else if (i_stat.cmd == CMD_LOAD) begin
                    o_ctl.mop    = MOP_LOAD;
                    o_ctl.set_st = 1'b1;
                    o_ctl.st     = ST_OK;
                    n_state      = S_FIN;
                end else if (i_stat.cmd == CMD_STEP) begin
                    n_state = S_STEP;
                end else if (i_stat.k_zero) begin
                    o_ctl.mop    = MOP_ZERO;
                    o_ctl.set_st = 1'b1;
                    o_ctl.st     = ST_OK;
                    n_state      = S_FIN;
                end else begin
                    // seek: fetch C(N,K) for the range check
                    o_ctl.rd_range = 1'b1;
                    n_state        = S_RANGE;
                end
            end
            S_STEP: begin
                o_ctl.mop    = i_stat.step_ok ? MOP_STEP : MOP_HOLD;
                o_ctl.set_st = 1'b1;
                o_ctl.st     = i_stat.step_ok ? ST_OK : ST_EXH;
                n_state      = S_FIN;
            end
            S_RANGE: begin
                if (i_stat.range_bad) begin
                    o_ctl.set_st = 1'b1;
                    o_ctl.st     = ST_RANGE;
                    n_state      = S_FIN;
                end else begin
                    o_ctl.walk_init = 1'b1;
                    n_state         = S_WRD;
                end
            end
            S_WRD: begin
                if (i_stat.walk_cont) begin
                    n_state = S_WCMP;
                end else begin
                    do_place = 1'b1;
                end
            end
            S_WCMP: begin
                if (i_stat.walk_take) begin
                    o_ctl.walk_take = 1'b1;
                    n_state         = S_WRD;
                end else begin
                    do_place = 1'b1;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
        endcase

        // place a one at the current position, or fail if it ran off the end
        if (do_place) begin
            if (i_stat.place_oob) begin
                o_ctl.set_st = 1'b1;
                o_ctl.st     = ST_RANGE;
                n_state      = S_FIN;
            end else begin
                o_ctl.walk_place = 1'b1;
                if (i_stat.place_last) begin
                    o_ctl.mop    = MOP_BUILT;
                    o_ctl.set_st = 1'b1;
                    o_ctl.st     = ST_OK;
                    n_state      = S_FIN;
                end else begin
                    n_state = S_WRD;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// File: sv/k_combination_mask_generator.sv
// K-of-N combination mask generator: load, next-permutation step and rank seek.
//
// Input channel (i_in_valid / o_in_stall) carries a command and a rank; each
// accepted transaction yields exactly one result transaction on the output
// channel (o_out_valid / i_out_stall) holding the mask after the command and
// a status code. Config writes (i_cfg_we, i_cfg_index, i_cfg_data) set N and K
// and are to be made while the block is idle; the block leaves this to the user.
// After reset the block builds its 65 x 65 binomial table in memory, one entry
// per cycle over the lower triangle: o_in_stall stays high until the table is
// built, the mask is zero, N is 1 and K is 0.
// One transaction is in flight at a time. Load, unused command, bad config and
// seek with K of zero go from dispatch straight to the finish state; step and a
// seek rank out of range pass through the step or range state first. A seek
// that walks loops over the walk states: the unrank walk reads the single
// binomial memory read port per position and skips it or places a one there.
// The result sits in an output register, so the next transaction is accepted
// while the result waits. While i_out_stall is high the result holds, and a
// finished command waits for the register to drain before its result loads.
`default_nettype none
module k_combination_mask_generator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire kcmg_pkg::t_cfg_idx            i_cfg_index,
    input  wire logic [kcmg_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire kcmg_pkg::t_cmd                i_command,
    input  wire logic [kcmg_pkg::MASK_W-1:0]   i_rank,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [kcmg_pkg::MASK_W-1:0]        o_mask,
    output kcmg_pkg::t_status                  o_status
);
    import kcmg_pkg::*;

    t_dp_cmd  ctl;
    t_dp_stat stat;

    kcmg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_ctl       (ctl)
    );

    kcmg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_command   (i_command),
        .i_rank      (i_rank),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .o_mask      (o_mask),
        .o_status    (o_status)
    );

`include "k_combination_mask_generator_assert.svh"

    `KCMG_ASSERT_NEXT(a_one_in_flight, i_in_valid && !o_in_stall, o_in_stall, "second transaction taken while busy")
    `KCMG_ASSERT_NOW(a_load_frees_input, $rose(o_out_valid), !o_in_stall, "result loaded but input still stalled")

endmodule
`default_nettype wire
